// ----- rtl/r2fft_pkg.sv -----
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared types, constants and the twiddle table of the radix-2 FFT block.
// ----------------------------------------------------------------------------
package r2fft_pkg;

   localparam int POINTS  = 256;
   localparam int LOG     = $clog2(POINTS);
   localparam int AW      = LOG;
   localparam int SW      = $clog2(LOG + 1);
   localparam int QTR     = POINTS / 4;
   localparam int TIW     = (QTR > 0) ? $clog2(QTR + 1) : 1;
   localparam int DW      = 25;
   localparam int SQ_W    = 2 * DW;
   localparam int SQ_ITER = DW;
   localparam int CW      = $clog2(SQ_ITER);

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam longint unsigned TAYLOR_DIV [0:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                    64'd110, 64'd156, 64'd210, 64'd272};

   typedef logic [14:0] tw_word_type;
   typedef tw_word_type tw_tab_type [0:QTR];

   typedef struct packed {
      logic          push_wr;
      logic          bf_mul;
      logic          bf_sum;
      logic          bf_wa;
      logic          bf_wb;
      logic          rd_mem;
      logic          rd_fix;
      logic          rd_sq;
      logic          sq_start;
      logic          load_res;
      logic          load_zero;
      logic          inv;
      logic [SW-1:0] stage;
      logic [AW-1:0] bfly;
      logic [AW-1:0] load_cnt;
      logic [AW-1:0] read_cnt;
   } cmd_type;

   typedef struct packed {
      logic out_full;
      logic sqrt_done;
   } sts_type;

   // sine of 2*pi*k/POINTS, Taylor series in Q2.30, rounded to Q1.15
   function automatic tw_tab_type build_tw();
      tw_tab_type      tab;
      longint unsigned x;
      longint unsigned term;
      longint          sum;
      for (int k = 0; k <= QTR; k++) begin
         x    = (PI_Q30 * 64'd2 * longint'(k)) / POINTS;
         term = x;
         sum  = longint'(x);
         for (int n = 1; n <= 8; n++) begin
            term = ((term * x) >> 30) * x >> 30;
            term = term / TAYLOR_DIV[n - 1];
            if (n % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         sum = (sum + 16384) >>> 15;
         tab[k] = (sum > 32767) ? 15'h7FFF : 15'(sum);
      end
      return tab;
   endfunction

   localparam tw_tab_type TW_TAB = build_tw();

   function automatic logic signed [DW-1:0] sat25(input logic signed [DW+3:0] v);
      logic signed [DW+3:0] hi;
      logic signed [DW+3:0] lo;
      hi = (DW+4)'(24'hFFFFFF);
      lo = -hi - (DW+4)'(1);
      if (v > hi) begin
         return DW'(hi);
      end else if (v < lo) begin
         return DW'(lo);
      end
      return DW'(v);
   endfunction

endpackage

// ----- rtl/radix2_fft_with_magnitude.sv -----
// ----------------------------------------------------------------------------
// radix2_fft_with_magnitude
// In-place radix-2 DIT FFT of 256 Q1.15 points with per-bin magnitude readout.
// ----------------------------------------------------------------------------
// The push that completes a frame starts the transform, which steps each
// butterfly through read, multiply, sum, write-a and write-b states with a single
// multiply/add unit and a memory with one write port, and it holds the input
// stalled until the last stage is done. A read beat steps through memory read,
// fix, square and add states, then waits on the bit-serial square root; a read
// before a frame is done returns at once with valid_res low. The inverse-mode
// register is sampled when the last sample of a frame is pushed.
module radix2_fft_with_magnitude
   import r2fft_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_command,
   input  logic signed [15:0]   req_real_part,
   input  logic signed [15:0]   req_imag_part,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [DW-1:0] rsp_real_result,
   output logic signed [DW-1:0] rsp_imag_result,
   output logic [23:0]          rsp_magnitude,
   output logic [7:0]           rsp_bin_index,
   output logic                 rsp_last_bin,
   output logic                 rsp_valid_res,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_inverse_mode
);

   cmd_type cmd;
   sts_type sts;

   r2fft_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_inverse_mode (csr_inverse_mode),
      .cmd              (cmd),
      .sts              (sts)
   );

   r2fft_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_real_part   (req_real_part),
      .req_imag_part   (req_imag_part),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_real_result (rsp_real_result),
      .rsp_imag_result (rsp_imag_result),
      .rsp_magnitude   (rsp_magnitude),
      .rsp_bin_index   (rsp_bin_index),
      .rsp_last_bin    (rsp_last_bin),
      .rsp_valid_res   (rsp_valid_res)
   );

`ifndef SYNTH
   a_no_accept_while_full: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("input accepted while a result beat is pending");

   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_magnitude == 24'd0 && !rsp_last_bin)
      else $error("invalid result beat carries data");

   a_last_is_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_bin |-> rsp_valid_res)
      else $error("last bin flagged on an invalid beat");
`endif

endmodule

// ----- rtl/r2fft_isqrt.sv -----
// ----------------------------------------------------------------------------
// r2fft_isqrt
// Bit-serial integer square root, one result bit per cycle, saturated to 24 bits.
// ----------------------------------------------------------------------------
module r2fft_isqrt
   import r2fft_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [SQ_W-1:0] value,
   output logic            done,
   output logic [23:0]     root
);

   logic [SQ_W-1:0] v_ff, v_in;
   logic [SQ_W-1:0] r_ff, r_in;
   logic [SQ_W-1:0] bit_ff, bit_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [SQ_W-1:0] trial;

   always_comb begin
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = r_ff + bit_ff;
      if (start) begin
         v_in    = value;
         r_in    = '0;
         bit_in  = SQ_W'(1) << (SQ_W - 2);
         cnt_in  = CW'(SQ_ITER - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = (r_ff[SQ_W-1:24] != '0) ? 24'hFFFFFF : r_ff[23:0];

endmodule

// ----- rtl/r2fft_dp.sv -----
// ----------------------------------------------------------------------------
// r2fft_dp
// Sample memory, butterfly unit, twiddle lookup, magnitude path and result register.
// ----------------------------------------------------------------------------
module r2fft_dp
   import r2fft_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  logic signed [15:0]   req_real_part,
   input  logic signed [15:0]   req_imag_part,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [DW-1:0] rsp_real_result,
   output logic signed [DW-1:0] rsp_imag_result,
   output logic [23:0]          rsp_magnitude,
   output logic [7:0]           rsp_bin_index,
   output logic                 rsp_last_bin,
   output logic                 rsp_valid_res
);

   logic [2*DW-1:0] mem [0:POINTS-1];
   logic [2*DW-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0]   rd_a_addr;

   logic [AW-1:0] half, mask, j_idx, a_addr, b_addr, t_idx, rev;
   logic          we;
   logic [AW-1:0] wr_addr;
   logic [2*DW-1:0] wr_data;

   logic signed [15:0] tw_re, tw_im, tw_re_ff, tw_im_ff;
   logic               swap;
   logic signed [DW-1:0] a_re, a_im, b_re, b_im;
   logic signed [DW-1:0] u_re_ff, u_im_ff;
   logic signed [40:0]   p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [42:0]   s_re, s_im;
   logic signed [27:0]   t_re_ff, t_im_ff;
   logic signed [DW-1:0] sa_re, sa_im, sb_re, sb_im;
   logic [2*DW-1:0]      b_res_ff;

   logic signed [DW-1:0] m_re, m_im;
   logic signed [DW-1:0] fx_re_ff, fx_im_ff;
   logic signed [SQ_W-1:0] sq_re, sq_im;
   logic [SQ_W-2:0]      sq_re_ff, sq_im_ff;
   logic                 sqrt_done;
   logic [23:0]          root;

   logic                 out_full_ff, out_full_in;

   for (genvar i = 0; i < LOG; i++) begin : g_rev
      assign rev[i] = cmd.load_cnt[LOG-1-i];
   end

   // butterfly addressing
   always_comb begin
      half   = AW'(1) << cmd.stage;
      mask   = half - AW'(1);
      j_idx  = cmd.bfly & mask;
      a_addr = ((cmd.bfly & ~mask) << 1) | j_idx;
      b_addr = a_addr | half;
      t_idx  = j_idx << (SW'(LOG - 1) - cmd.stage);
   end

   // twiddle lookup by quarter-wave symmetry
   always_comb begin
      if (t_idx == '0) begin
         tw_re = 16'sd32767;
         tw_im = 16'sd0;
      end else if (t_idx <= AW'(QTR)) begin
         tw_re = $signed({1'b0, TW_TAB[TIW'(AW'(QTR) - t_idx)]});
         tw_im = -$signed({1'b0, TW_TAB[TIW'(t_idx)]});
      end else begin
         tw_re = -$signed({1'b0, TW_TAB[TIW'(t_idx - AW'(QTR))]});
         tw_im = -$signed({1'b0, TW_TAB[TIW'(AW'(POINTS / 2) - t_idx)]});
      end
   end

   // write port
   always_comb begin
      we      = cmd.push_wr | cmd.bf_wa | cmd.bf_wb;
      wr_addr = rev;
      wr_data = {DW'(req_real_part), DW'(req_imag_part)};
      if (cmd.bf_wa) begin
         wr_addr = a_addr;
         wr_data = {sa_re, sa_im};
      end else if (cmd.bf_wb) begin
         wr_addr = b_addr;
         wr_data = b_res_ff;
      end
   end

   assign rd_a_addr = cmd.rd_mem ? cmd.read_cnt : a_addr;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[b_addr];
   end

   // operands, swapped on the first stage of an inverse transform, with the butterfly sums and magnitude squares
   always_comb begin
      swap = cmd.inv && (cmd.stage == '0);
      a_re = swap ? rd_a_ff[DW-1:0] : rd_a_ff[2*DW-1:DW];
      a_im = swap ? rd_a_ff[2*DW-1:DW] : rd_a_ff[DW-1:0];
      b_re = swap ? rd_b_ff[DW-1:0] : rd_b_ff[2*DW-1:DW];
      b_im = swap ? rd_b_ff[2*DW-1:DW] : rd_b_ff[DW-1:0];
      s_re = 43'(p_rr_ff) - 43'(p_ii_ff) + 43'sd16384;
      s_im = 43'(p_ri_ff) + 43'(p_ir_ff) + 43'sd16384;
      sa_re = sat25(29'(u_re_ff) + 29'(t_re_ff));
      sa_im = sat25(29'(u_im_ff) + 29'(t_im_ff));
      sb_re = sat25(29'(u_re_ff) - 29'(t_re_ff));
      sb_im = sat25(29'(u_im_ff) - 29'(t_im_ff));
      m_re  = rd_a_ff[2*DW-1:DW];
      m_im  = rd_a_ff[DW-1:0];
      sq_re = fx_re_ff * fx_re_ff;
      sq_im = fx_im_ff * fx_im_ff;
   end

   always_ff @(posedge clock) begin
      tw_re_ff <= tw_re;
      tw_im_ff <= tw_im;
      if (cmd.bf_mul) begin
         u_re_ff <= a_re;
         u_im_ff <= a_im;
         p_rr_ff <= tw_re_ff * b_re;
         p_ii_ff <= tw_im_ff * b_im;
         p_ri_ff <= tw_re_ff * b_im;
         p_ir_ff <= tw_im_ff * b_re;
      end
      if (cmd.bf_sum) begin
         t_re_ff <= s_re[42:15];
         t_im_ff <= s_im[42:15];
      end
      if (cmd.bf_wa) begin
         b_res_ff <= {sb_re, sb_im};
      end
      if (cmd.rd_fix) begin
         fx_re_ff <= cmd.inv ? (m_im >>> LOG) : m_re;
         fx_im_ff <= cmd.inv ? (m_re >>> LOG) : m_im;
      end
      if (cmd.rd_sq) begin
         sq_re_ff <= sq_re[SQ_W-2:0];
         sq_im_ff <= sq_im[SQ_W-2:0];
      end
   end

   r2fft_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sq_start),
      .value (SQ_W'(sq_re_ff) + SQ_W'(sq_im_ff)),
      .done  (sqrt_done),
      .root  (root)
   );

   // result register
   always_comb begin
      out_full_in = out_full_ff;
      if (out_full_ff && !rsp_stall) begin
         out_full_in = 1'b0;
      end
      if (cmd.load_res || cmd.load_zero) begin
         out_full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_full_ff <= 1'b0;
      end else begin
         out_full_ff <= out_full_in;
      end
      if (cmd.load_res) begin
         rsp_real_result <= fx_re_ff;
         rsp_imag_result <= fx_im_ff;
         rsp_magnitude   <= root;
         rsp_bin_index   <= 8'(cmd.read_cnt);
         rsp_last_bin    <= (cmd.read_cnt == AW'(POINTS - 1));
         rsp_valid_res   <= 1'b1;
      end else if (cmd.load_zero) begin
         rsp_real_result <= '0;
         rsp_imag_result <= '0;
         rsp_magnitude   <= '0;
         rsp_bin_index   <= '0;
         rsp_last_bin    <= 1'b0;
         rsp_valid_res   <= 1'b0;
      end
   end

   assign rsp_valid     = out_full_ff;
   assign sts.out_full  = out_full_ff;
   assign sts.sqrt_done = sqrt_done;

endmodule

// ----- rtl/r2fft_ctrl.sv -----
// ----------------------------------------------------------------------------
// r2fft_ctrl
// Frame sequencer: load counting, butterfly schedule, bin readout, mode register.
// ----------------------------------------------------------------------------
module r2fft_ctrl
   import r2fft_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  logic    req_command,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_inverse_mode,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_BF_RD   = 4'd1;
   localparam logic [3:0] S_BF_MUL  = 4'd2;
   localparam logic [3:0] S_BF_SUM  = 4'd3;
   localparam logic [3:0] S_BF_WA   = 4'd4;
   localparam logic [3:0] S_BF_WB   = 4'd5;
   localparam logic [3:0] S_RD_MEM  = 4'd6;
   localparam logic [3:0] S_RD_FIX  = 4'd7;
   localparam logic [3:0] S_RD_SQ   = 4'd8;
   localparam logic [3:0] S_RD_ADD  = 4'd9;
   localparam logic [3:0] S_RD_WAIT = 4'd10;

   logic [3:0]    state_ff, state_in;
   logic          mode_ff, mode_in;
   logic          inv_ff, inv_in;
   logic          done_ff, done_in;
   logic [AW-1:0] load_ff, load_in;
   logic [AW-1:0] read_ff, read_in;
   logic [SW-1:0] stage_ff, stage_in;
   logic [AW-1:0] bfly_ff, bfly_in;
   logic          accept;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE) || sts.out_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      mode_in  = (csr_valid && csr_ready) ? csr_inverse_mode : mode_ff;
      inv_in   = inv_ff;
      done_in  = done_ff;
      load_in  = load_ff;
      read_in  = read_ff;
      stage_in = stage_ff;
      bfly_in  = bfly_ff;
      cmd          = '0;
      cmd.inv      = inv_ff;
      cmd.stage    = stage_ff;
      cmd.bfly     = bfly_ff;
      cmd.load_cnt = load_ff;
      cmd.read_cnt = read_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_command == CMD_PUSH) begin
                  cmd.push_wr = 1'b1;
                  done_in     = 1'b0;
                  load_in     = load_ff + AW'(1);
                  if (load_ff == AW'(POINTS - 1)) begin
                     inv_in   = mode_ff;
                     stage_in = '0;
                     bfly_in  = '0;
                     load_in  = '0;
                     state_in = S_BF_RD;
                  end
               end else if (done_ff) begin
                  state_in = S_RD_MEM;
               end else begin
                  cmd.load_zero = 1'b1;
               end
            end
         end
         S_BF_RD:  state_in = S_BF_MUL;
         S_BF_MUL: begin
            cmd.bf_mul = 1'b1;
            state_in   = S_BF_SUM;
         end
         S_BF_SUM: begin
            cmd.bf_sum = 1'b1;
            state_in   = S_BF_WA;
         end
         S_BF_WA: begin
            cmd.bf_wa = 1'b1;
            state_in  = S_BF_WB;
         end
         S_BF_WB: begin
            cmd.bf_wb = 1'b1;
            bfly_in   = bfly_ff + AW'(1);
            state_in  = S_BF_RD;
            if (bfly_ff == AW'(POINTS / 2 - 1)) begin
               bfly_in = '0;
               if (stage_ff == SW'(LOG - 1)) begin
                  done_in  = 1'b1;
                  read_in  = '0;
                  state_in = S_IDLE;
               end else begin
                  stage_in = stage_ff + SW'(1);
               end
            end
         end
         S_RD_MEM: begin
            cmd.rd_mem = 1'b1;
            state_in   = S_RD_FIX;
         end
         S_RD_FIX: begin
            cmd.rd_fix = 1'b1;
            state_in   = S_RD_SQ;
         end
         S_RD_SQ: begin
            cmd.rd_sq = 1'b1;
            state_in  = S_RD_ADD;
         end
         S_RD_ADD: begin
            cmd.sq_start = 1'b1;
            state_in     = S_RD_WAIT;
         end
         S_RD_WAIT: begin
            if (sts.sqrt_done) begin
               cmd.load_res = 1'b1;
               read_in      = read_ff + AW'(1);
               state_in     = S_IDLE;
               if (read_ff == AW'(POINTS - 1)) begin
                  done_in = 1'b0;
                  read_in = '0;
                  load_in = '0;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= 1'b0;
         inv_ff   <= 1'b0;
         done_ff  <= 1'b0;
         load_ff  <= '0;
         read_ff  <= '0;
         stage_ff <= '0;
         bfly_ff  <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         inv_ff   <= inv_in;
         done_ff  <= done_in;
         load_ff  <= load_in;
         read_ff  <= read_in;
         stage_ff <= stage_in;
         bfly_ff  <= bfly_in;
      end
   end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 256-point radix-2 FFT with magnitude readout.
// Frames of samples are pushed in forward and inverse mode, and the bins are
// read back. Every returned bin is compared with a bit-exact fixed-point
// prediction of the transform. Both channels idle at random, and the result
// side also holds off for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import r2fft_pkg::*;

   localparam int IDLE_LIMIT  = 60000;
   localparam int CSR_SETTLE  = 6000;
   localparam int HOLD_CYCLES = 700;

   typedef struct {
      logic signed [DW-1:0] re;
      logic signed [DW-1:0] im;
      logic [23:0]          mag;
      logic [7:0]           idx;
      logic                 last;
      logic                 vres;
   } bin_type;

   class fft_scoreboard;
      longint  sine_q[0:QTR];
      longint  mem_re[POINTS];
      longint  mem_im[POINTS];
      int      load_cnt;
      int      read_cnt;
      bit      done;
      bit      inv;
      bin_type bins_due[$];
      int      errors;
      int      pushes;
      int      reads;

      function new();
         longint unsigned x;
         longint unsigned term;
         longint          sum;
         for (int k = 0; k <= QTR; k++) begin
            x    = (PI_Q30 * 64'd2 * longint'(k)) / POINTS;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 8; n++) begin
               term = ((term * x) >> 30) * x >> 30;
               term = term / longint'((2 * n) * (2 * n + 1));
               if (n % 2 == 1) sum = sum - longint'(term);
               else sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            sum = (sum + 16384) >>> 15;
            sine_q[k] = (sum > 32767) ? 32767 : sum;
         end
         for (int i = 0; i < POINTS; i++) begin
            mem_re[i] = 0;
            mem_im[i] = 0;
         end
         load_cnt = 0;
         read_cnt = 0;
         done     = 0;
         inv      = 0;
         errors   = 0;
         pushes   = 0;
         reads    = 0;
      endfunction

      function longint clip25(longint v);
         if (v > 16777215) return 16777215;
         if (v < -16777216) return -16777216;
         return v;
      endfunction

      function longint unsigned isqrt(longint unsigned v);
         longint unsigned r;
         longint unsigned b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function void run_transform();
         longint wr, wi, br, bi, ur, ui, tr, ti, tmp;
         int     half, step, a, b, t;
         if (inv) begin
            for (int i = 0; i < POINTS; i++) begin
               tmp = mem_re[i]; mem_re[i] = mem_im[i]; mem_im[i] = tmp;
            end
         end
         for (int m = 2; m <= POINTS; m = m * 2) begin
            half = m / 2;
            step = POINTS / m;
            for (int k = 0; k < POINTS; k += m) begin
               for (int j = 0; j < half; j++) begin
                  a = k + j;
                  b = k + j + half;
                  t = j * step;
                  if (t == 0) begin
                     wr = 32767; wi = 0;
                  end else if (t <= QTR) begin
                     wr = sine_q[QTR - t]; wi = -sine_q[t];
                  end else begin
                     wr = -sine_q[t - QTR]; wi = -sine_q[POINTS / 2 - t];
                  end
                  br = mem_re[b]; bi = mem_im[b];
                  ur = mem_re[a]; ui = mem_im[a];
                  tr = (wr * br - wi * bi + 16384) >>> 15;
                  ti = (wr * bi + wi * br + 16384) >>> 15;
                  mem_re[a] = clip25(ur + tr);
                  mem_re[b] = clip25(ur - tr);
                  mem_im[a] = clip25(ui + ti);
                  mem_im[b] = clip25(ui - ti);
               end
            end
         end
         if (inv) begin
            for (int i = 0; i < POINTS; i++) begin
               tmp = mem_re[i];
               mem_re[i] = mem_im[i] >>> LOG;
               mem_im[i] = tmp >>> LOG;
            end
         end
      endfunction

      function void note_sample(logic cmd, logic signed [15:0] re, logic signed [15:0] im);
         bin_type         e;
         int              a;
         longint          r, q;
         longint unsigned m;
         if (cmd == CMD_PUSH) begin
            pushes++;
            if (done) begin
               done = 0;
               load_cnt = 0;
            end
            a = 0;
            for (int i = 0; i < LOG; i++) a = (a << 1) | ((load_cnt >> i) & 1);
            mem_re[a] = re;
            mem_im[a] = im;
            load_cnt++;
            if (load_cnt >= POINTS) begin
               run_transform();
               done = 1;
               read_cnt = 0;
               load_cnt = 0;
            end
            return;
         end
         reads++;
         e = '{re: '0, im: '0, mag: '0, idx: '0, last: 1'b0, vres: 1'b0};
         if (done) begin
            r = mem_re[read_cnt];
            q = mem_im[read_cnt];
            m = isqrt(longint'(r * r) + longint'(q * q));
            e.re   = DW'(r);
            e.im   = DW'(q);
            e.mag  = (m > 16777215) ? 24'hFFFFFF : 24'(m);
            e.idx  = 8'(read_cnt);
            e.last = (read_cnt == POINTS - 1);
            e.vres = 1'b1;
            read_cnt++;
            if (read_cnt >= POINTS) begin
               done = 0;
               read_cnt = 0;
               load_cnt = 0;
            end
         end
         bins_due.push_back(e);
      endfunction

      function void check_bin(bin_type got);
         bin_type e;
         if (bins_due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat, bin %0d", got.idx);
            return;
         end
         e = bins_due.pop_front();
         if (got.re !== e.re || got.im !== e.im || got.mag !== e.mag || got.idx !== e.idx
             || got.last !== e.last || got.vres !== e.vres) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch exp re=%0d im=%0d mag=%0d bin=%0d last=%0b ok=%0b",
                        e.re, e.im, e.mag, e.idx, e.last, e.vres);
               $display("         got re=%0d im=%0d mag=%0d bin=%0d last=%0b ok=%0b",
                        got.re, got.im, got.mag, got.idx, got.last, got.vres);
            end
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_command = CMD_PUSH;
   logic signed [15:0]   req_real_part = '0;
   logic signed [15:0]   req_imag_part = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b1;
   logic signed [DW-1:0] rsp_real_result;
   logic signed [DW-1:0] rsp_imag_result;
   logic [23:0]          rsp_magnitude;
   logic [7:0]           rsp_bin_index;
   logic                 rsp_last_bin;
   logic                 rsp_valid_res;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic                 csr_inverse_mode = 1'b0;

   fft_scoreboard sb = new();
   int  idle_cycles = 0;
   bit  no_idle = 0;
   bit  hold_rsp = 0;
   bit  saw_inv = 0;

   always #5 clock = ~clock;

   radix2_fft_with_magnitude DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_real_part   (req_real_part),
      .req_imag_part   (req_imag_part),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_real_result (rsp_real_result),
      .rsp_imag_result (rsp_imag_result),
      .rsp_magnitude   (rsp_magnitude),
      .rsp_bin_index   (rsp_bin_index),
      .rsp_last_bin    (rsp_last_bin),
      .rsp_valid_res   (rsp_valid_res),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_inverse_mode(csr_inverse_mode)
   );

   // beat monitor
   always @(posedge clock) begin
      bit moved;
      moved = 0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            sb.inv = csr_inverse_mode;
            moved = 1;
         end
         if (req_valid && !req_stall) begin
            sb.note_sample(req_command, req_real_part, req_imag_part);
            moved = 1;
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_bin('{re: rsp_real_result, im: rsp_imag_result, mag: rsp_magnitude,
                           idx: rsp_bin_index, last: rsp_last_bin, vres: rsp_valid_res});
            moved = 1;
         end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("[radix2_fft_with_magnitude] ERROR");
      $finish;
   end

   // result side
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 0;
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         n = no_idle ? 0 : $urandom_range(0, 8);
         rsp_stall = 1'b1;
         repeat (n) @(negedge clock);
         rsp_stall = 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_beat(logic cmd, logic signed [15:0] re, logic signed [15:0] im);
      int n;
      n = no_idle ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
         req_valid = 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_command   = cmd;
      req_real_part = re;
      req_imag_part = im;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (sb.bins_due.size() != 0) @(negedge clock);
      repeat (CSR_SETTLE) @(negedge clock);
   endtask

   task automatic write_mode(logic v);
      settle();
      csr_valid        = 1'b1;
      csr_inverse_mode = v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
      if (v) saw_inv = 1;
   endtask

   function automatic logic signed [15:0] pick_sample(int kind);
      case (kind)
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 511)) - 256);
         default: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : -16'sh8000;
      endcase
   endfunction

   task automatic push_frame(int kind);
      logic signed [15:0] edges[6];
      edges = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh5555, -16'sh5556};
      for (int i = 0; i < POINTS; i++) begin
         if (kind == 0 && i < 6) begin
            send_beat(CMD_PUSH, edges[i], edges[5 - i]);
         end else begin
            if ($urandom_range(0, 99) < 3) send_beat(CMD_READ, pick_sample(0), pick_sample(0));
            send_beat(CMD_PUSH, pick_sample(kind), pick_sample(kind));
         end
      end
   endtask

   task automatic read_bins(int count);
      for (int i = 0; i < count; i++) send_beat(CMD_READ, pick_sample(0), pick_sample(0));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reads before any frame is loaded
      read_bins(2);
      write_mode(1'b0);

      // forward, extremes first, then a partial readout dropped by the next frame
      push_frame(0);
      read_bins(40);

      // inverse, samples back to back, then a full readout under a long hold
      write_mode(1'b1);
      no_idle = 1;
      push_frame(1);
      no_idle = 0;
      hold_rsp = 1;
      read_bins(POINTS + 1);

      req_valid = 1'b0;
      while (sb.bins_due.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);

      $display("pushed %0d samples and read %0d bins over two frames", sb.pushes, sb.reads);
      $display("inverse mode used: %0b, mismatches: %0d", saw_inv, sb.errors);
      if (sb.errors == 0 && sb.bins_due.size() == 0) begin
         $display("[radix2_fft_with_magnitude] OK");
      end else begin
         $display("[radix2_fft_with_magnitude] ERROR");
      end
      $finish;
   end

endmodule
